>>> rtl/core/kpc_pkg.sv
// ----------------------------------------------------------------------------
// kpc_pkg: shared types and constants of the key press classifier
// Event codes, register indexes, register reset values and the config bundle.
// ----------------------------------------------------------------------------
package kpc_pkg;

	// Register field, timer and event code widths
	localparam int unsigned TICK_W  = 8;
	localparam int unsigned LIMIT_W = 12;
	localparam int unsigned TIMER_W = 13;
	localparam int unsigned EVENT_W = 2;

	// APB geometry
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned IDX_W  = 3;

	// Event codes reported once per tick
	typedef enum logic [EVENT_W-1:0] {
		EV_NONE   = 2'd0,
		EV_SHORT  = 2'd1,
		EV_LONG   = 2'd2,
		EV_DOUBLE = 2'd3
	} event_t;

	// Register indexes (byte address = 4 * index)
	typedef enum logic [IDX_W-1:0] {
		REG_LONG_ENABLE   = 3'd0,
		REG_DOUBLE_ENABLE = 3'd1,
		REG_TICK_MS       = 3'd2,
		REG_LONG_LIMIT    = 3'd3,
		REG_SHORT_LIMIT   = 3'd4,
		REG_DOUBLE_GAP    = 3'd5
	} reg_idx_t;

	// Reset values
	localparam logic               RST_LONG_ENABLE   = 1'b1;
	localparam logic               RST_DOUBLE_ENABLE = 1'b0;
	localparam logic [TICK_W-1:0]  RST_TICK_MS       = 8'd20;
	localparam logic [LIMIT_W-1:0] RST_LONG_LIMIT    = 12'd800;
	localparam logic [LIMIT_W-1:0] RST_SHORT_LIMIT   = 12'd200;
	localparam logic [LIMIT_W-1:0] RST_DOUBLE_GAP    = 12'd200;

	// Configuration bundle from the register block to the classifier
	typedef struct packed {
		logic               long_enable;
		logic               double_enable;
		logic [TICK_W-1:0]  tick_ms;
		logic [LIMIT_W-1:0] long_limit;
		logic [LIMIT_W-1:0] short_limit;
		logic [LIMIT_W-1:0] double_gap;
	} cfg_t;

endpackage

>>> rtl/core/kpc_pin_if.sv
// ----------------------------------------------------------------------------
// kpc_pin_if: sampled key pin channel
// One transaction carries one sampling tick of the raw active-low pin.
// ----------------------------------------------------------------------------
interface kpc_pin_if;
	logic valid;
	logic ready;
	logic pin_level;

	modport source (output valid, output pin_level, input ready);
	modport sink (input valid, input pin_level, output ready);
endinterface

>>> rtl/core/kpc_event_if.sv
// ----------------------------------------------------------------------------
// kpc_event_if: key event channel
// One transaction carries the event code of one tick.
// ----------------------------------------------------------------------------
interface kpc_event_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_code;

	modport source (output valid, output event_code, input ready);
	modport sink (input valid, input event_code, output ready);
endinterface

>>> rtl/core/key_press_classifier.sv
// ----------------------------------------------------------------------------
// key_press_classifier: short / long / double press detector
// Classifies sampled ticks of an active-low key pin into key events.
// ----------------------------------------------------------------------------
// Each input transaction is one sampling tick and produces exactly one event
// transaction (none, short, long or double). A tick is registered on entry,
// classified against the key state while held in the input register and written
// to the output register; one tick is taken every cycle as long as the output is
// drained, and the only limit is the combinational timer add and compare path.
// The user must see that registers are written through the APB port only while
// no tick is in flight; the block does not enforce it. pready is always high.
module key_press_classifier (
	input  logic                       clk,
	input  logic                       arst_n,
	kpc_pin_if.sink                    key_in,
	kpc_event_if.source                event_out,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [kpc_pkg::ADDR_W-1:0] paddr,
	input  logic [kpc_pkg::DATA_W-1:0] pwdata,
	output logic [kpc_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import kpc_pkg::*;

	cfg_t   cfg;
	logic   valid_s1;
	logic   pin_s1;
	logic   valid_s2;
	event_t code_s2;
	event_t code;
	logic   adv;
	logic   step;

	kpc_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	kpc_classify u_classify (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.step       (step),
		.pin_level  (pin_s1),
		.event_code (code)
	);

	// Flow control: stage 2 frees when empty or taken, stage 1 when empty or when it moves on
	assign adv          = !valid_s2 || event_out.ready;
	assign step         = valid_s1 && adv;
	assign key_in.ready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (key_in.ready) begin
			valid_s1 <= key_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (key_in.ready && key_in.valid) begin
			pin_s1 <= key_in.pin_level;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			code_s2 <= code;
		end
	end

	assign event_out.valid      = valid_s2;
	assign event_out.event_code = code_s2;

endmodule

>>> rtl/core/kpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// kpc_cfg_regs: APB register block
// Holds the six configuration registers; writes to unmapped indexes are dropped.
// ----------------------------------------------------------------------------
module kpc_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [kpc_pkg::ADDR_W-1:0] paddr,
	input  logic [kpc_pkg::DATA_W-1:0] pwdata,
	output logic [kpc_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output kpc_pkg::cfg_t              cfg
);
	import kpc_pkg::*;

	cfg_t             cfg_q;
	logic             wr_en;
	logic [IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[ADDR_W-1:2];
	assign cfg    = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_enable   <= RST_LONG_ENABLE;
			cfg_q.double_enable <= RST_DOUBLE_ENABLE;
			cfg_q.tick_ms       <= RST_TICK_MS;
			cfg_q.long_limit    <= RST_LONG_LIMIT;
			cfg_q.short_limit   <= RST_SHORT_LIMIT;
			cfg_q.double_gap    <= RST_DOUBLE_GAP;
		end else if (wr_en) begin
			unique case (idx)
				REG_LONG_ENABLE:   cfg_q.long_enable   <= pwdata[0];
				REG_DOUBLE_ENABLE: cfg_q.double_enable <= pwdata[0];
				REG_TICK_MS:       cfg_q.tick_ms       <= pwdata[TICK_W-1:0];
				REG_LONG_LIMIT:    cfg_q.long_limit    <= pwdata[LIMIT_W-1:0];
				REG_SHORT_LIMIT:   cfg_q.short_limit   <= pwdata[LIMIT_W-1:0];
				REG_DOUBLE_GAP:    cfg_q.double_gap    <= pwdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_LONG_ENABLE:   prdata[0] = cfg_q.long_enable;
			REG_DOUBLE_ENABLE: prdata[0] = cfg_q.double_enable;
			REG_TICK_MS:       prdata[TICK_W-1:0] = cfg_q.tick_ms;
			REG_LONG_LIMIT:    prdata[LIMIT_W-1:0] = cfg_q.long_limit;
			REG_SHORT_LIMIT:   prdata[LIMIT_W-1:0] = cfg_q.short_limit;
			REG_DOUBLE_GAP:    prdata[LIMIT_W-1:0] = cfg_q.double_gap;
			default:           prdata = '0;
		endcase
	end

endmodule

>>> rtl/core/kpc_classify.sv
// ----------------------------------------------------------------------------
// kpc_classify: press classification state and next-state logic
// Holds the key state and both timers; one tick is applied when step is high.
// ----------------------------------------------------------------------------
module kpc_classify (
	input  logic                 clk,
	input  logic                 arst_n,
	input  kpc_pkg::cfg_t        cfg,
	input  logic                 step,
	input  logic                 pin_level,
	output kpc_pkg::event_t      event_code
);
	import kpc_pkg::*;

	logic               prev_pressed_q;
	logic [TIMER_W-1:0] hold_time_q;
	logic               first_release_q;
	logic [TIMER_W-1:0] gap_time_q;

	logic               now;
	logic [TIMER_W-1:0] hold_d;
	logic [TIMER_W-1:0] gap_d;
	logic               first_d;
	event_t             code;
	logic [TIMER_W-1:0] tick_ext;
	logic [TIMER_W-1:0] long_ext;
	logic [TIMER_W-1:0] short_ext;
	logic [TIMER_W-1:0] gap_ext;

	assign now       = ~pin_level;
	assign tick_ext  = {{(TIMER_W-TICK_W){1'b0}}, cfg.tick_ms};
	assign long_ext  = {{(TIMER_W-LIMIT_W){1'b0}}, cfg.long_limit};
	assign short_ext = {{(TIMER_W-LIMIT_W){1'b0}}, cfg.short_limit};
	assign gap_ext   = {{(TIMER_W-LIMIT_W){1'b0}}, cfg.double_gap};

	// Rules applied in order; a later rule overrides the event code
	always_comb begin
		hold_d  = hold_time_q;
		gap_d   = gap_time_q;
		first_d = first_release_q;
		code    = EV_NONE;

		// press edge
		if (!prev_pressed_q && now && cfg.long_enable) begin
			hold_d = '0;
		end
		// holding
		if (prev_pressed_q && now && cfg.long_enable && (hold_d <= long_ext)) begin
			hold_d = hold_d + tick_ext;
		end
		// long press, repeats while held
		if (prev_pressed_q && cfg.long_enable && (hold_d > long_ext)) begin
			code   = EV_LONG;
			hold_d = short_ext + {{(TIMER_W-1){1'b0}}, 1'b1};
		end
		// release after a short hold
		if (prev_pressed_q && !now && (hold_d <= short_ext)) begin
			if (!cfg.double_enable) begin
				code = EV_SHORT;
			end else if (!first_d) begin
				first_d = 1'b1;
				gap_d   = '0;
			end else if (gap_d <= gap_ext) begin
				code    = EV_DOUBLE;
				first_d = 1'b0;
			end
		end
		// gap timeout turns a pending first release into a short press
		if (first_d) begin
			gap_d = gap_d + tick_ext;
			if (gap_d > gap_ext) begin
				code    = EV_SHORT;
				first_d = 1'b0;
			end
		end
	end

	assign event_code = code;

	// State update once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pressed_q  <= 1'b0;
			hold_time_q     <= '0;
			first_release_q <= 1'b0;
			gap_time_q      <= '0;
		end else if (step) begin
			prev_pressed_q  <= now;
			hold_time_q     <= hold_d;
			first_release_q <= first_d;
			gap_time_q      <= gap_d;
		end
	end

endmodule

>>> bench/tb_key_press_classifier.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_key_press_classifier: self-checking bench of the key press classifier
// Sampling ticks go in on the pin channel and event codes come back on the
// event channel. A behavioral copy of the key state predicts each event. The
// sender runs in bursts, the receiver stalls on its own pattern, and the
// registers are rewritten through APB between phases.
// ----------------------------------------------------------------------------
module tb_key_press_classifier;
	import kpc_pkg::*;

	localparam int unsigned MAX_RUN     = 80;
	localparam int unsigned PHASE_TICKS = 250;
	localparam int unsigned NUM_PHASES  = 7;

	logic clk;
	logic arst_n;

	kpc_pin_if   pin_ch ();
	kpc_event_if ev_ch ();

	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	key_press_classifier u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_in    (pin_ch),
		.event_out (ev_ch),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// Shadow of the registers and of the key state
	cfg_t               key_cfg;
	logic               was_pressed;
	logic [TIMER_W-1:0] hold_ms;
	logic               release_pending;
	logic [TIMER_W-1:0] gap_ms;

	event_t      pending_events[$];
	event_t      oldest_event;
	int unsigned error_count;
	int unsigned ticks_sent;

	// Sender burst shaping and receiver stall control
	int unsigned burst_left;
	bit          gaps_on;
	int unsigned hold_off_cycles;
	logic [7:0]  stall_mask;
	int unsigned stall_slot;

	always #2 clk = ~clk;

	// Classify one tick against the shadow state; later rules override earlier ones
	function automatic event_t classify_tick(input logic pin);
		logic   last;
		logic   now;
		event_t code;
		last = was_pressed;
		now = ~pin;
		code = EV_NONE;
		was_pressed = now;
		if (!last && now && key_cfg.long_enable)
			hold_ms = '0;
		if (last && now && key_cfg.long_enable && hold_ms <= key_cfg.long_limit)
			hold_ms = hold_ms + key_cfg.tick_ms;
		if (last && key_cfg.long_enable && hold_ms > key_cfg.long_limit) begin
			code = EV_LONG;
			hold_ms = {1'b0, key_cfg.short_limit} + 13'd1;
		end
		if (last && !now && hold_ms <= key_cfg.short_limit) begin
			if (!key_cfg.double_enable) begin
				code = EV_SHORT;
			end else if (!release_pending) begin
				release_pending = 1'b1;
				gap_ms = '0;
			end else if (gap_ms <= key_cfg.double_gap) begin
				code = EV_DOUBLE;
				release_pending = 1'b0;
			end
		end
		// Gap timeout turns a lone release into a short press
		if (release_pending) begin
			gap_ms = gap_ms + key_cfg.tick_ms;
			if (gap_ms > key_cfg.double_gap) begin
				code = EV_SHORT;
				release_pending = 1'b0;
			end
		end
		return code;
	endfunction

	// Run length in ticks, kept between 1 and MAX_RUN
	function automatic int unsigned clamp_run(input int unsigned n);
		if (n == 0)
			return 1;
		return (n > MAX_RUN) ? MAX_RUN : n;
	endfunction

	// Send one tick; called at a falling edge, returns at a falling edge
	task automatic send_tick(input logic pin);
		if (burst_left == 0) begin
			pin_ch.valid = 1'b0;
			if (gaps_on)
				repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 12);
		end
		burst_left--;
		pin_ch.valid = 1'b1;
		pin_ch.pin_level = pin;
		@(posedge clk);
		while (!pin_ch.ready)
			@(posedge clk);
		pending_events.push_back(classify_tick(pin));
		ticks_sent++;
		@(negedge clk);
	endtask

	// Send n ticks, the leftmost written bit first
	task automatic send_pins(input logic [15:0] pins, input int n);
		for (int i = n - 1; i >= 0; i--)
			send_tick(pins[i]);
	endtask

	// Stop offering ticks until every event has come back and the pipe is empty
	task automatic wait_idle();
		pin_ch.valid = 1'b0;
		while (pending_events.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// APB write followed by a read back of the same register
	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] readback;
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_LONG_ENABLE:   key_cfg.long_enable = value[0];
			REG_DOUBLE_ENABLE: key_cfg.double_enable = value[0];
			REG_TICK_MS:       key_cfg.tick_ms = value[TICK_W-1:0];
			REG_LONG_LIMIT:    key_cfg.long_limit = value[LIMIT_W-1:0];
			REG_SHORT_LIMIT:   key_cfg.short_limit = value[LIMIT_W-1:0];
			REG_DOUBLE_GAP:    key_cfg.double_gap = value[LIMIT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		psel = 1'b1;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		readback = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		if (readback !== value) begin
			$error("prdata mismatch at index %0d: expected %0d, actual %0d",
				idx, value, readback);
			error_count++;
		end
	endtask

	task automatic set_config(input logic long_en, input logic double_en,
		input int unsigned tick, input int unsigned long_lim,
		input int unsigned short_lim, input int unsigned gap_lim);
		write_reg(REG_LONG_ENABLE, DATA_W'(long_en));
		write_reg(REG_DOUBLE_ENABLE, DATA_W'(double_en));
		write_reg(REG_TICK_MS, tick);
		write_reg(REG_LONG_LIMIT, long_lim);
		write_reg(REG_SHORT_LIMIT, short_lim);
		write_reg(REG_DOUBLE_GAP, gap_lim);
	endtask

	// Reset values: a brief press then release gives a short press
	task automatic test_default_config();
		send_pins(16'b1001, 4);
		wait_idle();
	endtask

	// Long press with the longest tick, then a long event on every tick after the press edge
	task automatic test_long_press();
		set_config(1'b1, 1'b0, 255, 300, 0, 200);
		send_pins(16'b00001, 5);
		wait_idle();
		write_reg(REG_LONG_LIMIT, 0);
		write_reg(REG_SHORT_LIMIT, 4095);
		send_pins(16'b001, 3);
		wait_idle();
	endtask

	// Double press, then a second release that arrives after the gap shrank
	task automatic test_double_press();
		set_config(1'b1, 1'b1, 255, 4095, 4095, 4095);
		send_pins(16'b0101, 4);
		send_pins(16'b010, 3);
		wait_idle();
		write_reg(REG_DOUBLE_GAP, 0);
		send_pins(16'b1, 1);
		wait_idle();
	endtask

	// Hold timer frozen: the release is still judged on the stale hold time
	task automatic test_long_disabled();
		set_config(1'b0, 1'b0, 1, 4095, 0, 0);
		send_pins(16'b001, 3);
		wait_idle();
	endtask

	// Receiver holds off while ticks keep coming so the input must stall
	task automatic test_output_backpressure();
		set_config(1'b1, 1'b1, 40, 200, 100, 120);
		hold_off_cycles = 150;
		gaps_on = 1'b0;
		repeat (5) begin
			repeat (4) send_tick(1'b0);
			repeat (4) send_tick(1'b1);
		end
		gaps_on = 1'b1;
		wait_idle();
	endtask

	// Random press sequences sized to each phase's timing
	task automatic test_random_sequences();
		int unsigned tick;
		int unsigned span;
		int unsigned phase_end;
		int unsigned press_n;
		int unsigned release_n;
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: set_config(1'b1, 1'b1, 255, 4095, 4095, 4095);
				1: set_config(1'b0, 1'b0, 1, 0, 0, 0);
				default: begin
					tick = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255)
						: $urandom_range(10, 80);
					span = (tick * 30 > 4095) ? 4095 : tick * 30;
					set_config($urandom_range(0, 3) != 0, $urandom_range(0, 1) != 0,
						tick, $urandom_range(0, span), $urandom_range(0, span / 2),
						$urandom_range(0, span / 2));
				end
			endcase
			tick = 32'(key_cfg.tick_ms);
			phase_end = ticks_sent + PHASE_TICKS;
			while (ticks_sent < phase_end) begin
				press_n = 0;
				case ($urandom_range(0, 9))
					0, 1, 2: press_n = $urandom_range(1, clamp_run(key_cfg.short_limit / tick + 1));
					3, 4:    press_n = clamp_run(key_cfg.long_limit / tick + $urandom_range(1, 8));
					5:       repeat ($urandom_range(1, 3)) send_tick(1'($urandom_range(0, 1)));
					default: press_n = $urandom_range(1, clamp_run(key_cfg.long_limit / tick + 4));
				endcase
				repeat (press_n) send_tick(1'b0);
				if ($urandom_range(0, 1) == 0)
					release_n = $urandom_range(1, clamp_run(key_cfg.double_gap / tick + 1));
				else
					release_n = clamp_run(key_cfg.double_gap / tick + $urandom_range(1, 6));
				repeat (release_n) send_tick(1'b1);
				if ($urandom_range(0, 49) == 0)
					wait_idle();
			end
			wait_idle();
		end
	endtask

	// Receiver: long hold-off when requested, else a changing stall pattern
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			ev_ch.ready = 1'b0;
			hold_off_cycles--;
		end else begin
			if (stall_slot % 32 == 0) begin
				case ($urandom_range(0, 3))
					0: stall_mask = 8'h00;
					1: stall_mask = 8'($urandom);
					2: stall_mask = 8'($urandom & $urandom);
					default: stall_mask = 8'hFE;
				endcase
			end
			ev_ch.ready = ~stall_mask[stall_slot % 8];
			stall_slot++;
		end
	end

	// Compare each event transaction with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && ev_ch.valid && ev_ch.ready) begin
			if (pending_events.size() == 0) begin
				$error("event_code: no event expected, actual %0d", ev_ch.event_code);
				error_count++;
			end else begin
				oldest_event = pending_events.pop_front();
				if (ev_ch.event_code !== oldest_event) begin
					$error("event_code mismatch: expected %0d, actual %0d",
						oldest_event, ev_ch.event_code);
					error_count++;
				end
			end
		end
	end

	// Run limit
	initial begin
		#(2_000_000);
		$display("key_press_classifier test failed");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		pin_ch.valid = 1'b0;
		pin_ch.pin_level = 1'b1;
		ev_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		key_cfg.long_enable = RST_LONG_ENABLE;
		key_cfg.double_enable = RST_DOUBLE_ENABLE;
		key_cfg.tick_ms = RST_TICK_MS;
		key_cfg.long_limit = RST_LONG_LIMIT;
		key_cfg.short_limit = RST_SHORT_LIMIT;
		key_cfg.double_gap = RST_DOUBLE_GAP;
		was_pressed = 1'b0;
		hold_ms = '0;
		release_pending = 1'b0;
		gap_ms = '0;
		error_count = 0;
		ticks_sent = 0;
		burst_left = 0;
		gaps_on = 1'b1;
		hold_off_cycles = 0;
		stall_mask = 8'h00;
		stall_slot = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_default_config();
		test_long_press();
		test_double_press();
		test_long_disabled();
		test_output_backpressure();
		test_random_sequences();

		wait_idle();
		repeat (8) @(posedge clk);
		if (error_count == 0 && pending_events.size() == 0)
			$display("key_press_classifier test passed");
		else
			$display("key_press_classifier test failed");
		$finish;
	end

endmodule
